### sv/smds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smds_pkg
// Types, constants and helper functions for the decimal digit stream core.
// ----------------------------------------------------------------------------
package smds_pkg;

	localparam int unsigned STATE_W   = 64;
	localparam int unsigned COUNT_W   = 17;
	localparam int unsigned TOTAL_W   = 16;
	localparam int unsigned PART_W    = 10;
	localparam int unsigned BCD_W     = 48;
	localparam int unsigned NIBBLES   = BCD_W / 4;
	localparam int unsigned REM_W     = 30;
	localparam int unsigned CNT_W     = 6;

	localparam logic [STATE_W-1:0] GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [STATE_W-1:0] MIX1  = 64'hbf58476d1ce4e5b9;
	localparam logic [STATE_W-1:0] MIX2  = 64'h94d049bb133111eb;
	localparam logic [REM_W-1:0]   MODULUS = 30'd1000000000;

	localparam int unsigned XS1_SH   = 30;
	localparam int unsigned XS2_SH   = 27;
	localparam int unsigned XS3_SH   = 31;
	localparam int unsigned NANOS_SH = 16;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd10000;
	localparam logic [3:0]         SEED_DIGITS = 4'd12;
	localparam logic [3:0]         DRAW_DIGITS = 4'd9;
	localparam logic [CNT_W-1:0]   SEED_LAST   = 6'd9;
	localparam logic [CNT_W-1:0]   DRAW_LAST   = 6'd29;
	localparam logic [CNT_W-1:0]   WORD_LAST   = 6'd63;
	localparam logic [PART_W-1:0]  PART_MAX    = 10'd999;

	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [STATE_W-1:0]   tick_count;
		logic [PART_W-1:0]    millis;
		logic [PART_W-1:0]    micros;
		logic [PART_W-1:0]    nanos;
		logic [PART_W-1:0]    picos;
		logic [STATE_W-1:0]   epoch_seconds;
	} smds_in_t;

	typedef struct packed {
		logic [BCD_W-1:0] digits_bcd;
		logic [3:0]       digits_valid;
		logic             final_chunk;
	} smds_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_XS1,
		S_MUL1,
		S_XS2,
		S_MUL2,
		S_XS3,
		S_MOD,
		S_CONV,
		S_DONE
	} smds_state_t;

	function automatic logic [PART_W-1:0] sat_part(input logic [PART_W-1:0] v);
		return (v > PART_MAX) ? PART_MAX : v;
	endfunction

	// double-dabble add-3 step on every nibble
	function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		r = v;
		for (int i = 0; i < NIBBLES; i++) begin
			if (v[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = v[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	function automatic logic bcd_ok(input logic [BCD_W-1:0] v);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < NIBBLES; i++) begin
			if (v[4*i +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

### sv/splitmix_decimal_digit_stream_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// splitmix_decimal_digit_stream_core
// Timestamp-seeded splitmix64 generator emitting packed BCD digit chunks.
// ----------------------------------------------------------------------------
// One transaction at a time. After a seed transaction is accepted, its 12
// timestamp digits go through 10 double-dabble steps on four 3-digit lanes,
// then the output load. After a draw transaction, nine digits follow: the
// two 64x64 multiplies of the mixer run bit-serially on one shared 64-bit
// adder, each after an xor-shift, the reduction mod 1e9 takes one state bit
// per cycle after a third xor-shift, then come the binary to BCD conversion
// and the output load, which waits while out_valid is high and out_ready is
// low. digits_valid caps either chunk at the digits left of the digit total.
// A draw after the digit total is reached goes straight to the output load
// without advancing the generator. A finished result sits in the output
// register, so the next transaction can be accepted while it waits.
// digit_total may only be written while the core is idle.
module splitmix_decimal_digit_stream_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  smds_pkg::smds_in_t     in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output smds_pkg::smds_out_t    out_data,
	input  wire                    cfg_we,
	input  wire [15:0]             cfg_wdata
);
	import smds_pkg::*;

	smds_state_t        state_q, state_d;
	logic [TOTAL_W-1:0] total_q;
	logic [STATE_W-1:0] gen_q;
	logic [COUNT_W-1:0] emitted_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	smds_out_t          out_q;

	logic [STATE_W-1:0] a_q, acc_q;
	logic [REM_W-1:0]   r_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [3:0]         valid_q;
	logic               final_q;
	logic               is_seed_q;

	logic               in_acc, out_load, cnt_end;
	logic [COUNT_W-1:0] total_x, remaining, emitted_nx;
	logic [3:0]         valid_nx;
	logic               draw_empty;
	logic               mul_bit;
	logic [STATE_W-1:0] mul_sum;
	logic [REM_W:0]     mod_t;
	logic [REM_W-1:0]   r_nx;
	logic [BCD_W-1:0]   bcd_adj, bcd_nx;
	logic [CNT_W-1:0]   conv_last;

	assign total_x    = {1'b0, total_q};
	assign remaining  = (total_x > emitted_q) ? total_x - emitted_q : '0;
	assign draw_empty = (remaining == '0);

	always_comb begin
		if (in_data.cmd == CMD_SEED) begin
			valid_nx   = (total_q < {12'd0, SEED_DIGITS}) ? total_q[3:0] : SEED_DIGITS;
			emitted_nx = {13'd0, valid_nx};
		end else if (draw_empty) begin
			valid_nx   = 4'd0;
			emitted_nx = emitted_q;
		end else begin
			valid_nx   = (remaining < {13'd0, DRAW_DIGITS}) ? remaining[3:0] : DRAW_DIGITS;
			emitted_nx = emitted_q + {13'd0, valid_nx};
		end
	end

	assign mul_bit = (state_q == S_MUL1) ? MIX1[cnt_q] : MIX2[cnt_q];
	assign mul_sum = acc_q + (mul_bit ? a_q : '0);

	assign mod_t = {r_q, a_q[STATE_W-1]};
	assign r_nx  = (mod_t >= {1'b0, MODULUS}) ? REM_W'(mod_t - {1'b0, MODULUS})
	                                          : mod_t[REM_W-1:0];

	assign bcd_adj   = dd_adjust(bcd_q);
	assign conv_last = is_seed_q ? SEED_LAST : DRAW_LAST;

	always_comb begin
		if (is_seed_q) begin
			bcd_nx = {bcd_adj[46:36], a_q[63], bcd_adj[34:24], a_q[53],
			          bcd_adj[22:12], a_q[43], bcd_adj[10:0],  a_q[33]};
		end else begin
			bcd_nx = {bcd_adj[BCD_W-2:0], a_q[STATE_W-1]};
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		in_acc   = 1'b0;
		out_load = 1'b0;
		cnt_end  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				in_acc   = in_valid;
				if (in_valid) begin
					if (in_data.cmd == CMD_SEED) begin
						state_d = S_CONV;
					end else if (draw_empty) begin
						state_d = S_DONE;
					end else begin
						state_d = S_XS1;
					end
				end
			end
			S_XS1: state_d = S_MUL1;
			S_MUL1: begin
				cnt_end = (cnt_q == WORD_LAST);
				if (cnt_end) begin
					state_d = S_XS2;
				end
			end
			S_XS2: state_d = S_MUL2;
			S_MUL2: begin
				cnt_end = (cnt_q == WORD_LAST);
				if (cnt_end) begin
					state_d = S_XS3;
				end
			end
			S_XS3: state_d = S_MOD;
			S_MOD: begin
				cnt_end = (cnt_q == WORD_LAST);
				if (cnt_end) begin
					state_d = S_CONV;
				end
			end
			S_CONV: begin
				cnt_end = (cnt_q == conv_last);
				if (cnt_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= TOTAL_RESET;
			gen_q       <= '0;
			emitted_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (in_acc) begin
				emitted_q <= emitted_nx;
				if (in_data.cmd == CMD_SEED) begin
					gen_q <= in_data.tick_count ^ in_data.epoch_seconds ^
					         ({{(STATE_W-PART_W){1'b0}}, in_data.nanos} << NANOS_SH);
				end else if (!draw_empty) begin
					gen_q <= gen_q + GAMMA;
				end
			end
			if (in_acc || cnt_end) begin
				cnt_q <= '0;
			end else if (state_q == S_MUL1 || state_q == S_MUL2 ||
			             state_q == S_MOD || state_q == S_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			is_seed_q <= (in_data.cmd == CMD_SEED);
			valid_q   <= valid_nx;
			final_q   <= (emitted_nx >= total_x);
			bcd_q     <= '0;
			a_q       <= {sat_part(in_data.millis), sat_part(in_data.micros),
			              sat_part(in_data.nanos), sat_part(in_data.picos),
			              {(STATE_W-4*PART_W){1'b0}}};
		end
		unique case (state_q)
			S_XS1: begin
				a_q   <= gen_q ^ (gen_q >> XS1_SH);
				acc_q <= '0;
			end
			S_MUL1, S_MUL2: begin
				acc_q <= mul_sum;
				a_q   <= a_q << 1;
			end
			S_XS2: begin
				a_q   <= acc_q ^ (acc_q >> XS2_SH);
				acc_q <= '0;
			end
			S_XS3: begin
				a_q <= acc_q ^ (acc_q >> XS3_SH);
				r_q <= '0;
			end
			S_MOD: begin
				if (cnt_end) begin
					a_q   <= {r_nx, {(STATE_W-REM_W){1'b0}}};
					bcd_q <= '0;
				end else begin
					a_q <= a_q << 1;
					r_q <= r_nx;
				end
			end
			S_CONV: begin
				bcd_q <= bcd_nx;
				a_q   <= a_q << 1;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.digits_bcd   <= bcd_q;
			out_q.digits_valid <= valid_q;
			out_q.final_chunk  <= final_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOD |-> r_q < MODULUS)
		else $error("remainder out of range");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> bcd_ok(bcd_q))
		else $error("non-decimal nibble in result");

	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.digits_valid <= SEED_DIGITS)
		else $error("digit count above twelve");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_valid_q || out_ready) |=>
			out_valid_q && state_q == S_IDLE)
		else $error("result not delivered to output register");

endmodule
`default_nettype wire

### sim/tb_splitmix_decimal_digit_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_splitmix_decimal_digit_stream_core
// Self-checking bench for the timestamp-seeded splitmix64 BCD digit core.
// A queue-fed driver offers seed and draw transactions with random gaps. A
// built-in generator model predicts every chunk at acceptance, and the monitor
// compares each result field by field. The bench runs a directed block first,
// then random phases with varying digit totals. The receiver stalls at random
// and holds off for long stretches so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_splitmix_decimal_digit_stream_core;

	import smds_pkg::smds_in_t;
	import smds_pkg::smds_out_t;
	import smds_pkg::CMD_SEED;
	import smds_pkg::CMD_DRAW;

	localparam logic [63:0] SM_GAMMA   = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL_B   = 64'h94d049bb133111eb;
	localparam logic [63:0] DEC_MOD    = 64'd1000000000;
	localparam int          RAND_ITEMS = 1930;
	localparam int          PHASE_LEN  = 60;
	localparam int          HOLD_LEN   = 1500;
	localparam int          SETTLE     = 16;
	localparam int          TAIL       = 300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	smds_in_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	smds_out_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	// generator model
	logic [63:0] gen_state   = 64'd0;
	logic [16:0] digits_done = 17'd0;
	logic [15:0] digit_limit = 16'd10000;

	smds_in_t    item_queue[$];
	smds_out_t   chunks_due[$];

	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int tx_gap = 0;
	int rx_wait = 0;
	int hold_left = 0;
	int holds_done = 0;
	int results_seen = 0;
	int fail_count = 0;
	int hold_at[2] = '{100, 1200};

	splitmix_decimal_digit_stream_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [47:0] to_bcd(input logic [63:0] v, input int nd);
		logic [47:0] r;
		r = '0;
		for (int i = 0; i < nd; i++) begin
			r[4*i +: 4] = 4'(v % 64'd10);
			v = v / 64'd10;
		end
		return r;
	endfunction

	function automatic logic [11:0] part_bcd(input logic [9:0] p);
		logic [47:0] r;
		r = to_bcd((p > 10'd999) ? 64'd999 : {54'd0, p}, 3);
		return r[11:0];
	endfunction

	function automatic smds_out_t predict_chunk(input smds_in_t it);
		smds_out_t   res;
		logic [16:0] remaining;
		logic [63:0] z;
		res = '0;
		remaining = ({1'b0, digit_limit} > digits_done) ?
			{1'b0, digit_limit} - digits_done : 17'd0;
		if (it.cmd == CMD_SEED) begin
			gen_state = it.tick_count ^ ({54'd0, it.nanos} << 16) ^ it.epoch_seconds;
			res.digits_bcd = {part_bcd(it.millis), part_bcd(it.micros),
				part_bcd(it.nanos), part_bcd(it.picos)};
			res.digits_valid = (digit_limit < 16'd12) ? digit_limit[3:0] : 4'd12;
			digits_done = {13'd0, res.digits_valid};
		end else if (remaining != 17'd0) begin
			gen_state = gen_state + SM_GAMMA;
			z = gen_state;
			z = (z ^ (z >> 30)) * SM_MUL_A;
			z = (z ^ (z >> 27)) * SM_MUL_B;
			z = z ^ (z >> 31);
			res.digits_bcd = to_bcd(z % DEC_MOD, 9);
			res.digits_valid = (remaining < 17'd9) ? remaining[3:0] : 4'd9;
			digits_done = digits_done + {13'd0, res.digits_valid};
		end
		res.final_chunk = (digits_done >= {1'b0, digit_limit});
		return res;
	endfunction

	function automatic smds_in_t build_item(input logic cmd, input logic [63:0] tick,
		input logic [9:0] ms, input logic [9:0] us, input logic [9:0] ns,
		input logic [9:0] ps, input logic [63:0] epoch);
		smds_in_t it;
		it.cmd = cmd;
		it.tick_count = tick;
		it.millis = ms;
		it.micros = us;
		it.nanos = ns;
		it.picos = ps;
		it.epoch_seconds = epoch;
		return it;
	endfunction

	function automatic logic [9:0] rand_part();
		return ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1000, 1023)) :
			10'($urandom_range(0, 999));
	endfunction

	function automatic smds_in_t rand_item(input logic cmd);
		return build_item(cmd, {$urandom, $urandom}, rand_part(), rand_part(),
			rand_part(), rand_part(), {$urandom, $urandom});
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				chunks_due.push_back(predict_chunk(in_data));
				tx_gap = tx_burst ? 0 : $urandom_range(0, 8);
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (item_queue.size() > 0) begin
					in_data <= item_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		smds_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (chunks_due.size() == 0) begin
					$error("result with no transaction pending: %h", out_data);
					fail_count++;
				end else begin
					want = chunks_due.pop_front();
					if (out_data.digits_bcd !== want.digits_bcd) begin
						$error("digits_bcd: expected %h, got %h",
							want.digits_bcd, out_data.digits_bcd);
						fail_count++;
					end
					if (out_data.digits_valid !== want.digits_valid) begin
						$error("digits_valid: expected %0d, got %0d",
							want.digits_valid, out_data.digits_valid);
						fail_count++;
					end
					if (out_data.final_chunk !== want.final_chunk) begin
						$error("final_chunk: expected %0b, got %0b",
							want.final_chunk, out_data.final_chunk);
						fail_count++;
					end
				end
				rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
			end
			if (hold_left == 0 && holds_done < 2 && results_seen >= hold_at[holds_done] &&
				item_queue.size() >= 8) begin
				hold_left = HOLD_LEN;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (item_queue.size() != 0 || in_valid || chunks_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_digit_limit(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		digit_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int queued;
		int lim;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset total; draws before any seed, extreme seeds, saturated parts
		item_queue.push_back(rand_item(CMD_DRAW));
		item_queue.push_back(rand_item(CMD_DRAW));
		item_queue.push_back(build_item(CMD_SEED, '1, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, '1));
		item_queue.push_back(build_item(CMD_SEED, '0, 10'd0, 10'd0, 10'd0, 10'd0, '0));
		item_queue.push_back(rand_item(CMD_DRAW));
		item_queue.push_back(build_item(CMD_SEED, {$urandom, $urandom}, 10'd1000, 10'd999,
			10'd0, 10'd512, {$urandom, $urandom}));
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();

		// zero total
		set_digit_limit(16'd0);
		item_queue.push_back(rand_item(CMD_SEED));
		item_queue.push_back(rand_item(CMD_DRAW));
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();

		// short totals on seed
		set_digit_limit(16'd5);
		item_queue.push_back(rand_item(CMD_SEED));
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();

		// partial last draw, then nothing left
		set_digit_limit(16'd20);
		item_queue.push_back(rand_item(CMD_SEED));
		item_queue.push_back(rand_item(CMD_DRAW));
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();

		set_digit_limit(16'd30);
		item_queue.push_back(rand_item(CMD_SEED));
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();
		// total lowered below the emitted count
		set_digit_limit(16'd15);
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();
		set_digit_limit(16'hffff);
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();
		set_digit_limit(16'd12);
		item_queue.push_back(rand_item(CMD_SEED));
		item_queue.push_back(rand_item(CMD_DRAW));
		wait_drained();

		queued = 0;
		while (queued < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0: lim = 0;
				1: lim = 65535;
				2: lim = $urandom_range(1, 11);
				3: lim = 12;
				4: lim = $urandom_range(0, 65535);
				default: lim = $urandom_range(13, 80);
			endcase
			set_digit_limit(16'(lim));
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			n = 0;
			// carry on from the previous state now and then
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					item_queue.push_back(rand_item(CMD_DRAW));
					n++;
				end
			end
			while (n < PHASE_LEN) begin
				if ($urandom_range(0, 9) < 8) begin
					item_queue.push_back(rand_item(CMD_SEED));
					n++;
					repeat ((lim / 9 + $urandom_range(0, 3) > 20) ? $urandom_range(1, 20) :
						lim / 9 + $urandom_range(0, 3)) begin
						item_queue.push_back(rand_item(CMD_DRAW));
						n++;
					end
				end else begin
					repeat ($urandom_range(1, 4)) begin
						item_queue.push_back(rand_item(1'($urandom_range(0, 1))));
						n++;
					end
				end
			end
			queued += n;
			wait_drained();
		end

		repeat (TAIL) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(64'd25_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
sv/smds_pkg.sv
sv/splitmix_decimal_digit_stream_core.sv
sim/tb_splitmix_decimal_digit_stream_core.sv
